>>> sv/esd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

	localparam int BYTE_W       = 8;
	localparam int NUM_W        = 9;
	localparam int MAX_RESULTS  = 3;
	localparam int OCTAL_DIGITS = 3;
	localparam int HEX_DIGITS   = 2;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] ASCII_MAX = 8'd127;
	localparam logic [4:0] NOT_HEX   = 5'd16;

	// Bytes produced by one word, in order, and how many of them are valid.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
		logic [1:0]                         cnt;
	} emit_t;

	function automatic emit_t emit_push(emit_t e, logic [BYTE_W-1:0] b);
		emit_t r;
		r = e;
		if (e.cnt != 2'(MAX_RESULTS)) begin
			r.data[e.cnt] = b;
			r.cnt = e.cnt + 2'd1;
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] control_code(logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		unique case (b)
			8'h61:   r = 8'd7;
			8'h62:   r = 8'd8;
			8'h66:   r = 8'd12;
			8'h6E:   r = 8'd10;
			8'h72:   r = 8'd13;
			8'h74:   r = 8'd9;
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] hex_value(logic [BYTE_W-1:0] b);
		logic [4:0] r;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = 5'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = 5'(b - 8'h41 + 8'd10);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = 5'(b - 8'h61 + 8'd10);
		end else begin
			r = NOT_HEX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/esd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface esd_in_if
	import esd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface esd_out_if
	import esd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

>>> sv/escape_sequence_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                   Handshake
// text      in   in_byte[8], end_of_text   valid/ready
// decoded   out  out_byte[8], run_last     valid/ready
//
// A word is registered on acceptance and, once the buffer can take it, decoded into a
// buffer of up to three result words, which drain one per cycle unless decoded stalls.
// With decoded ready, one word per cycle is sustained while each word yields at most
// one result; a word that yields n results holds the buffer until all n have drained.
// Reset clears the escape state and empties both the input stage and the buffer.
// A stalled output fills the buffer and then the input stage before text.ready drops.

module escape_sequence_decoder_core
	import esd_pkg::*;
#(
	parameter int OCTAL_DIGITS = esd_pkg::OCTAL_DIGITS,
	parameter int HEX_DIGITS   = esd_pkg::HEX_DIGITS
) (
	input  wire        clk,
	input  wire        arst_n,
	esd_in_if.sink     text,
	esd_out_if.source  decoded
);

	localparam logic [1:0] OctLimit = 2'(OCTAL_DIGITS);
	localparam logic [1:0] HexLimit = 2'(HEX_DIGITS);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_BSLASH,
		MODE_OCT,
		MODE_HEX_LO,
		MODE_HEX_UP
	} mode_t;

	mode_t                              mode_q, mode_d;
	logic [1:0]                         dcnt_q, dcnt_d;
	logic [NUM_W-1:0]                   val_q, val_d;

	logic                               valid_s1;
	logic [BYTE_W-1:0]                  byte_s1;
	logic                               eot_s1;

	logic [1:0]                         cnt_q;
	logic [MAX_RESULTS-1:0][BYTE_W-1:0] data_q;

	emit_t                              emit;
	logic                               pop;
	logic                               can_load;
	logic                               advance;
	logic                               accept;

	assign pop      = decoded.valid && decoded.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && decoded.ready);
	assign advance  = valid_s1 && can_load;
	assign accept   = text.valid && text.ready;

	assign text.ready       = !valid_s1 || can_load;
	assign decoded.valid    = cnt_q != 2'd0;
	assign decoded.out_byte = data_q[0];
	assign decoded.run_last = cnt_q == 2'd1;

	always_comb begin
		logic             do_plain;
		logic             do_take;
		logic             hex_base;
		logic [3:0]       digit;
		logic [4:0]       hv;
		logic [1:0]       lim;
		logic [BYTE_W-1:0] b;

		b        = byte_s1;
		emit     = '0;
		mode_d   = mode_q;
		dcnt_d   = dcnt_q;
		val_d    = val_q;
		do_plain = 1'b0;
		do_take  = 1'b0;
		hex_base = 1'b0;
		lim      = OctLimit;
		digit    = 4'(b - CH_ZERO);
		hv       = hex_value(b);

		unique case (mode_q)
			MODE_BSLASH: begin
				mode_d = MODE_IDLE;
				dcnt_d = 2'd0;
				val_d  = '0;
				if (b == CH_BSLASH || b > ASCII_MAX) begin
					emit = emit_push(emit, b);
				end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
					mode_d  = MODE_OCT;
					do_take = 1'b1;
				end else if (b == CH_EIGHT || b == CH_NINE) begin
					emit = emit_push(emit, CH_BSLASH);
					emit = emit_push(emit, b);
				end else if (b == CH_X_LO) begin
					mode_d = MODE_HEX_LO;
				end else if (b == CH_X_UP) begin
					mode_d = MODE_HEX_UP;
				end else begin
					emit = emit_push(emit, control_code(b));
				end
			end
			MODE_OCT: begin
				if (b >= CH_ZERO && b <= CH_SEVEN) begin
					do_take = 1'b1;
				end else begin
					emit     = emit_push(emit, val_q[BYTE_W-1:0]);
					do_plain = 1'b1;
				end
			end
			MODE_HEX_LO, MODE_HEX_UP: begin
				if (hv != NOT_HEX) begin
					do_take  = 1'b1;
					hex_base = 1'b1;
					digit    = hv[3:0];
				end else if (dcnt_q == 2'd0) begin
					emit = emit_push(emit, CH_BSLASH);
					emit = emit_push(emit, (mode_q == MODE_HEX_UP) ? CH_X_UP : CH_X_LO);
					do_plain = 1'b1;
				end else begin
					emit     = emit_push(emit, val_q[BYTE_W-1:0]);
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_take) begin
			lim = hex_base ? HexLimit : OctLimit;
			if (hex_base) begin
				val_d = {val_d[NUM_W-5:0], 4'b0000} + NUM_W'(digit);
			end else begin
				val_d = {val_d[NUM_W-4:0], 3'b000} + NUM_W'(digit);
			end
			dcnt_d = dcnt_d + 2'd1;
			if (dcnt_d >= lim) begin
				emit   = emit_push(emit, val_d[BYTE_W-1:0]);
				mode_d = MODE_IDLE;
				dcnt_d = 2'd0;
				val_d  = '0;
			end
		end

		if (do_plain) begin
			mode_d = MODE_IDLE;
			dcnt_d = 2'd0;
			val_d  = '0;
			if (b == CH_BSLASH) begin
				mode_d = MODE_BSLASH;
			end else begin
				emit = emit_push(emit, b);
			end
		end

		if (eot_s1) begin
			unique case (mode_d)
				MODE_BSLASH: begin
					emit = emit_push(emit, '0);
				end
				MODE_OCT: begin
					emit = emit_push(emit, val_d[BYTE_W-1:0]);
				end
				MODE_HEX_LO, MODE_HEX_UP: begin
					if (dcnt_d == 2'd0) begin
						emit = emit_push(emit, CH_BSLASH);
						emit = emit_push(emit,
							(mode_d == MODE_HEX_UP) ? CH_X_UP : CH_X_LO);
					end else begin
						emit = emit_push(emit, val_d[BYTE_W-1:0]);
					end
				end
				default: begin
				end
			endcase
			mode_d = MODE_IDLE;
			dcnt_d = 2'd0;
			val_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
			dcnt_q   <= 2'd0;
			val_q    <= '0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q <= mode_d;
				dcnt_q <= dcnt_d;
				val_q  <= val_d;
				cnt_q  <= emit.cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text.in_byte;
			eot_s1  <= text.end_of_text;
		end
		if (advance) begin
			data_q <= emit.data;
		end else if (pop) begin
			data_q[0] <= data_q[1];
			data_q[1] <= data_q[2];
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (dcnt_q == 2'd0 && val_q == '0))
		else $error("idle escape state holds a pending number");

	a_bslash_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_BSLASH) |-> (dcnt_q == 2'd0 && val_q == '0))
		else $error("backslash state holds a pending number");

	a_oct_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_OCT) |-> (dcnt_q != 2'd0 && dcnt_q < OctLimit))
		else $error("octal digit count out of range");

	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eot_s1) |=> (mode_q == MODE_IDLE))
		else $error("escape state pending after end of text");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (cnt_q == 2'd0 || pop))
		else $error("result buffer overwritten before drained");

endmodule

`default_nettype wire
